// ----- hw/rtl/ucsp_pkg.sv -----
// package: shared constants and types for the unit-cost shortest path unit
`timescale 1ns / 1ps
package ucsp_pkg;
    localparam int NodesDefault = 64;
    localparam int EdgesDefault = 512;

    typedef enum logic [1:0] {
        MODE_CLEAR = 2'd0,
        MODE_ADD   = 2'd1,
        MODE_QUERY = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_NOPATH = 2'd2;

    typedef struct packed {
        logic [1:0] mode;
        logic [5:0] node_a;
        logic [5:0] node_b;
    } in_word_t;

    typedef struct packed {
        logic [1:0] status;
        logic [5:0] path_node;
        logic       last;
    } out_word_t;
endpackage

// ----- hw/rtl/ucsp_if.sv -----
// interface: valid/ready channel carrying one word
`timescale 1ns / 1ps
interface ucsp_if #(parameter int W = 9);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/ucsp_out_reg.sv -----
// output register: holds one result word until the sink takes it
`timescale 1ns / 1ps
module ucsp_out_reg (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  ucsp_pkg::out_word_t  word,
    output logic                 full,
    ucsp_if.source               out_ch
);
    logic                full_reg;
    ucsp_pkg::out_word_t word_reg;

    assign full         = full_reg;
    assign out_ch.valid = full_reg;
    assign out_ch.data  = word_reg;

    // hold flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else if (push)
        begin
            full_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            full_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            word_reg <= word;
        end
    end
endmodule

// ----- hw/rtl/unit_cost_shortest_path_unit.sv -----
// top level: adjacency store in memories and breadth-first search sequencer
//  channel | dir | fields
//  in_ch   | in  | mode[1:0] node_a[5:0] node_b[5:0]
//  out_ch  | out | status[1:0] path_node[5:0] last
// clear goes straight to the result; add reads the tail of node a, then writes
// the entry; a query seeds the queue, dequeues each node, reads the head and tail
// of those with a list, scans their adjacency entries, then walks the parents and
// emits the path, each step paced by the single read port of each memory.
// clear also sweeps the per-node head valid bits at once (flip-flops).
// every result waits in the output register; the sequencer stalls while it is full.
`timescale 1ns / 1ps
module unit_cost_shortest_path_unit #(
    parameter int NODES = ucsp_pkg::NodesDefault,
    parameter int EDGES = ucsp_pkg::EdgesDefault
) (
    input logic clk,
    input logic rst_n,
    ucsp_if.sink   in_ch,
    ucsp_if.source out_ch
);
    localparam int NW = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int EW = $clog2(EDGES);
    localparam int CW = $clog2(EDGES + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_ADDW, S_ADD, S_QINIT, S_DEQ, S_DEQW, S_NWAIT, S_ELOAD, S_EWAIT,
        S_EVIS, S_PWALK, S_PWAIT, S_EMIT, S_EMITW, S_RESULT
    } state_t;

    // memories
    logic [EW-1:0] head_mem   [NODES];
    logic [EW-1:0] tail_mem   [NODES];
    logic [5:0]    nbr_mem    [EDGES];
    logic [EW-1:0] link_mem   [EDGES];
    logic [5:0]    parent_mem [NODES];
    logic [5:0]    queue_mem  [NODES];
    logic [5:0]    stack_mem  [NODES];

    logic [NODES-1:0] valid_reg, visited_reg;
    state_t           state_reg;
    logic [CW-1:0]    count_reg;
    logic [5:0]       a_reg, b_reg, n_reg, v_reg;
    logic [EW-1:0]    e_reg, tail_reg;
    logic [NW:0]      qhead_reg, qtail_reg, depth_reg;
    logic [CW-1:0]    steps_reg;
    logic [1:0]       st_reg;
    logic [EW-1:0]    head_rd, tail_rd, link_rd;
    logic [5:0]       nbr_rd, parent_rd, queue_rd, stack_rd;
    logic             push, ofull;
    ucsp_pkg::out_word_t owrd;
    ucsp_pkg::in_word_t  iw;

    assign iw          = in_ch.data;
    assign in_ch.ready = (state_reg == S_IDLE);

    ucsp_out_reg u_out (
        .clk(clk), .rst_n(rst_n), .push(push), .word(owrd), .full(ofull),
        .out_ch(out_ch)
    );

    // result word toward the output register
    assign push = ((state_reg == S_EMITW) || (state_reg == S_RESULT)) && !ofull;

    always_comb
    begin
        if (state_reg == S_RESULT)
        begin
            owrd.status    = st_reg;
            owrd.path_node = '0;
            owrd.last      = 1'b1;
        end
        else
        begin
            owrd.status    = ucsp_pkg::ST_OK;
            owrd.path_node = stack_rd;
            owrd.last      = (depth_reg == (NW+1)'(1));
        end
    end

    // synchronous reads
    always_ff @(posedge clk)
    begin
        head_rd   <= head_mem[n_reg[NW-1:0]];
        tail_rd   <= tail_mem[n_reg[NW-1:0]];
        nbr_rd    <= nbr_mem[e_reg];
        link_rd   <= link_mem[e_reg];
        parent_rd <= parent_mem[v_reg[NW-1:0]];
        queue_rd  <= queue_mem[qhead_reg[NW-1:0]];
        stack_rd  <= stack_mem[depth_reg[NW-1:0] - NW'(1)];
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            valid_reg   <= '0;
            visited_reg <= '0;
            count_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_ch.valid)
                    begin
                        a_reg <= iw.node_a;
                        b_reg <= iw.node_b;
                        n_reg <= iw.node_a;
                        st_reg <= ucsp_pkg::ST_OK;
                        case (iw.mode)
                            ucsp_pkg::MODE_CLEAR:
                            begin
                                valid_reg <= '0;
                                count_reg <= '0;
                                state_reg <= S_RESULT;
                            end
                            ucsp_pkg::MODE_ADD:
                            begin
                                if (32'(iw.node_a) >= NODES || 32'(iw.node_b) >= NODES)
                                    state_reg <= S_RESULT;
                                else if (32'(count_reg) >= EDGES)
                                begin
                                    st_reg    <= ucsp_pkg::ST_FULL;
                                    state_reg <= S_RESULT;
                                end
                                else
                                    state_reg <= S_ADDW;
                            end
                            ucsp_pkg::MODE_QUERY:
                            begin
                                if (32'(iw.node_a) >= NODES || 32'(iw.node_b) >= NODES)
                                begin
                                    st_reg    <= ucsp_pkg::ST_NOPATH;
                                    state_reg <= S_RESULT;
                                end
                                else
                                    state_reg <= S_QINIT;
                            end
                            default: state_reg <= S_IDLE;
                        endcase
                    end
                end
                // tail read of node a is issued here
                S_ADDW: state_reg <= S_ADD;
                // tail_rd valid now for node a
                S_ADD:
                begin
                    nbr_mem[count_reg[EW-1:0]] <= b_reg;
                    if (valid_reg[a_reg[NW-1:0]])
                        link_mem[tail_rd] <= count_reg[EW-1:0];
                    else
                    begin
                        valid_reg[a_reg[NW-1:0]] <= 1'b1;
                        head_mem[a_reg[NW-1:0]]  <= count_reg[EW-1:0];
                    end
                    tail_mem[a_reg[NW-1:0]] <= count_reg[EW-1:0];
                    count_reg <= count_reg + CW'(1);
                    state_reg <= S_RESULT;
                end
                S_QINIT:
                begin
                    visited_reg <= {{(NODES-1){1'b0}}, 1'b1} << a_reg[NW-1:0];
                    parent_mem[a_reg[NW-1:0]] <= a_reg;
                    queue_mem[0] <= a_reg;
                    qhead_reg <= '0;
                    qtail_reg <= (NW+1)'(1);
                    state_reg <= S_DEQ;
                end
                S_DEQ:
                begin
                    if (qhead_reg < qtail_reg)
                        state_reg <= S_DEQW;
                    else
                    begin
                        st_reg    <= ucsp_pkg::ST_NOPATH;
                        state_reg <= S_RESULT;
                    end
                end
                S_DEQW:
                begin
                    n_reg     <= queue_rd;
                    qhead_reg <= qhead_reg + (NW+1)'(1);
                    if (queue_rd == b_reg)
                    begin
                        v_reg     <= b_reg;
                        stack_mem[0] <= b_reg;
                        depth_reg <= (NW+1)'(1);
                        state_reg <= (b_reg == a_reg) ? S_EMIT : S_PWALK;
                    end
                    else if (!valid_reg[queue_rd[NW-1:0]])
                        state_reg <= S_DEQ;
                    else
                        state_reg <= S_NWAIT;
                end
                // head/tail reads of the new n are issued here
                S_NWAIT: state_reg <= S_ELOAD;
                // head/tail reads of n land here
                S_ELOAD:
                begin
                    e_reg     <= head_rd;
                    tail_reg  <= tail_rd;
                    steps_reg <= '0;
                    state_reg <= S_EWAIT;
                end
                S_EWAIT: state_reg <= S_EVIS;
                S_EVIS:
                begin
                    if (!visited_reg[nbr_rd[NW-1:0]] && 32'(nbr_rd) < NODES
                        && 32'(qtail_reg) < NODES)
                    begin
                        visited_reg[nbr_rd[NW-1:0]] <= 1'b1;
                        parent_mem[nbr_rd[NW-1:0]]  <= n_reg;
                        queue_mem[qtail_reg[NW-1:0]] <= nbr_rd;
                        qtail_reg <= qtail_reg + (NW+1)'(1);
                    end
                    if (e_reg == tail_reg || 32'(steps_reg) + 1 >= EDGES)
                        state_reg <= S_DEQ;
                    else
                    begin
                        e_reg     <= link_rd;
                        steps_reg <= steps_reg + CW'(1);
                        state_reg <= S_EWAIT;
                    end
                end
                S_PWALK: state_reg <= S_PWAIT;
                S_PWAIT:
                begin
                    v_reg <= parent_rd;
                    stack_mem[depth_reg[NW-1:0]] <= parent_rd;
                    depth_reg <= depth_reg + (NW+1)'(1);
                    if (parent_rd == a_reg || 32'(depth_reg) + 1 >= NODES)
                        state_reg <= S_EMIT;
                    else
                        state_reg <= S_PWALK;
                end
                S_EMIT: state_reg <= S_EMITW;
                S_EMITW:
                begin
                    if (!ofull)
                    begin
                        depth_reg <= depth_reg - (NW+1)'(1);
                        state_reg <= (depth_reg == (NW+1)'(1)) ? S_IDLE : S_EMIT;
                    end
                end
                S_RESULT:
                begin
                    if (!ofull)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
